// ===== rtl/core/lpfs_pkg.sv =====
// Shared types, codes and pattern ROM for the LED pattern fade sequencer.
// No dependencies; used by every module in rtl/core except lpfs_checker.
package lpfs_pkg;

    localparam int ROM_MODES  = 5;
    localparam int ROM_STAGES = 8;
    localparam int MS_W       = 12;
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 8;
    localparam int CH_N       = 3;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_PAUSE  = 2'd2,
        OP_RESUME = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK_CHK,
        S_PICK_CHK,
        S_BEGIN,
        S_WAIT_DUR,
        S_WAIT_FADE,
        S_APPLY,
        S_CH,
        S_WAIT_CH,
        S_POST,
        S_FADE_STEP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_DUR  = 2'd0,
        DIV_FADE = 2'd1,
        DIV_MAG  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic       cap;
        logic       tick_inc;
        logic       en_write_item;
        logic       en_clr_cur;
        logic       pause;
        logic       stage_inc;
        logic       stage_zero;
        logic       repeat_inc;
        logic       pick;
        logic       blank;
        logic       div_start;
        div_sel_t   div_sel;
        logic       set_deadline;
        logic       latch_ft;
        logic       jump;
        logic       fade_setup;
        logic       step_zero;
        logic       step_latch;
        logic [1:0] ch;
        logic       fade_on;
        logic       fade_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic mode_ok;
        logic deadline_hit;
        logic last_stage;
        logic keep_going;
        logic pick_change;
        logic stage_in;
        logic div_done;
        logic ft_zero;
        logic mag_zero;
        logic fade_active;
    } status_t;

    typedef struct packed {
        logic [7:0]      r;
        logic [7:0]      g;
        logic [7:0]      b;
        logic [MS_W-1:0] dur;
        logic [MS_W-1:0] fade;
    } stage_t;

    function automatic logic [3:0] rom_count(input logic [2:0] m);
        case (m)
            3'd0:    rom_count = 4'd1;
            3'd1:    rom_count = 4'd2;
            3'd2:    rom_count = 4'd2;
            3'd3:    rom_count = 4'd4;
            3'd4:    rom_count = 4'd8;
            default: rom_count = 4'd1;
        endcase
    endfunction

    function automatic logic rom_forever(input logic [2:0] m);
        rom_forever = (m == 3'd1) || (m == 3'd2) || (m == 3'd3);
    endfunction

    function automatic logic [CNT_W-1:0] rom_passes(input logic [2:0] m);
        rom_passes = (m == 3'd4) ? 8'd1 : 8'd0;
    endfunction

    function automatic stage_t mk(input logic [7:0] l, input logic blue_only,
                                  input int dur, input int fade);
        stage_t s;
        s.r    = blue_only ? 8'd0 : l;
        s.g    = blue_only ? 8'd0 : l;
        s.b    = l;
        s.dur  = MS_W'(dur);
        s.fade = MS_W'(fade);
        return s;
    endfunction

    function automatic stage_t stage_rom(input logic [2:0] m, input logic [2:0] s);
        stage_t v;
        v = mk(8'd0, 1'b0, 0, 0);
        case (m)
            3'd1:
            begin
                v = (s == 3'd0) ? mk(8'd0, 1'b0, 50, 0) : mk(8'd0, 1'b0, 50, 0);
                if (s == 3'd0)
                begin
                    v.r = 8'd255;
                end
            end
            3'd2: v = (s == 3'd0) ? mk(8'd255, 1'b1, 500, 150) : mk(8'd0, 1'b1, 500, 150);
            3'd3:
            begin
                case (s)
                    3'd0:    v = mk(8'd255, 1'b1, 150, 150);
                    3'd1:    v = mk(8'd0, 1'b1, 200, 0);
                    3'd2:    v = mk(8'd255, 1'b1, 150, 150);
                    default: v = mk(8'd0, 1'b1, 1000, 150);
                endcase
            end
            3'd4:
            begin
                case (s)
                    3'd0:    v = mk(8'd255, 1'b0, 3000, 3000);
                    3'd1:    v = mk(8'd0, 1'b0, 500, 150);
                    3'd7:    v = mk(8'd0, 1'b0, 200, 0);
                    default: v = mk(s[0] ? 8'd0 : 8'd255, 1'b0, 50, 0);
                endcase
            end
            default: v = mk(8'd0, 1'b0, 0, 0);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/led_pattern_fade_sequencer.sv =====
// LED pattern fade sequencer, top level.
// Input channel (in_valid/in_stall) takes one word per command: operation,
// mode, enable. Output channel (out_valid/out_stall) returns exactly one
// result word per command: red, green, blue, fading, shown_mode, stage_index.
// The APB port holds tick_period_ms at address 0 (paddr[2] selects the word).
// Commands are handled one at a time; the next word is taken the cycle after
// a result is loaded. Pause and ignored mode writes go from dispatch
// straight to the result.
// A command that starts a stage runs the shared divider (12 quotient steps)
// twice (duration, fade ticks), and a fading stage once more per changing
// colour channel.
// The result sits in an output register; a new command is taken while it
// waits, but its own result is held back until the receiver drops out_stall.
// Reset clears the sequencer to mode none, black, no fade, period 10 ms.
// Depends on lpfs_pkg, lpfs_ctrl, lpfs_datapath, lpfs_div.
module led_pattern_fade_sequencer
    import lpfs_pkg::*;
#(
    parameter int MODE_COUNT = 5,
    parameter int MAX_STAGES = 8,
    parameter int STEP_LIMIT = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  mode,
    input  logic        enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        fading,
    output logic [2:0]  shown_mode,
    output logic [3:0]  stage_index
);
    logic [9:0] period_reg;
    cmd_t       cmd;
    status_t    st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 10'd10;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            period_reg <= pwdata[9:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {22'd0, period_reg};

    lpfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    lpfs_datapath #(
        .MODE_COUNT (MODE_COUNT),
        .MAX_STAGES (MAX_STAGES),
        .STEP_LIMIT (STEP_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .mode        (mode),
        .enable      (enable),
        .period      (period_reg),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .fading      (fading),
        .shown_mode  (shown_mode),
        .stage_index (stage_index)
    );
endmodule

// ===== rtl/core/lpfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on lpfs_pkg for the operand width.
module lpfs_div
    import lpfs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MS_W-1:0] num,
    input  logic [MS_W-1:0] den,
    output logic            done,
    output logic [MS_W-1:0] quo
);
    localparam int CW = $clog2(MS_W + 1);

    logic [MS_W-1:0] q_reg, q_next;
    logic [MS_W-1:0] d_reg, d_next;
    logic [MS_W:0]   r_reg, r_next;
    logic [CW-1:0]   c_reg, c_next;
    logic            done_reg, done_next;
    logic [MS_W:0]   sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            c_reg    <= c_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        done_next = 1'b0;
        sh        = {r_reg[MS_W-1:0], q_reg[MS_W-1]};
        if (start)
        begin
            q_next = num;
            d_next = den;
            r_next = '0;
            c_next = CW'(MS_W);
        end
        else if (c_reg != '0)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[MS_W-2:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[MS_W-2:0], 1'b0};
            end
            c_next = c_reg - 1'b1;
            done_next = (c_reg == CW'(1));
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== rtl/core/lpfs_ctrl.sv =====
// Sequencer state machine: walks each word through its steps and drives
// the datapath commands. Depends on lpfs_pkg.
module lpfs_ctrl
    import lpfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    [1:0] operation,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t st,
    output cmd_t    cmd
);
    state_t     state_reg, state_next;
    op_t        op_reg, op_next;
    logic       force_reg, force_next;
    logic       fa_reg, fa_next;
    logic [1:0] ch_reg, ch_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_TICK;
            force_reg <= 1'b0;
            fa_reg    <= 1'b0;
            ch_reg    <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            force_reg <= force_next;
            fa_reg    <= fa_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        force_next = force_reg;
        fa_next    = fa_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.div_sel = DIV_DUR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    op_next    = op_t'(operation);
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                fa_next    = 1'b0;
                force_next = 1'b0;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = S_TICK_CHK;
                    end
                    OP_SET:
                    begin
                        cmd.en_write_item = st.mode_ok;
                        state_next = st.mode_ok ? S_PICK_CHK : S_DONE;
                    end
                    OP_PAUSE:
                    begin
                        cmd.pause  = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        force_next = 1'b1;
                        state_next = S_PICK_CHK;
                    end
                endcase
            end
            S_TICK_CHK:
            begin
                if (!st.running)
                begin
                    state_next = S_DONE;
                end
                else if (st.deadline_hit)
                begin
                    cmd.stage_inc = 1'b1;
                    if (!st.last_stage)
                    begin
                        fa_next    = 1'b1;
                        state_next = S_BEGIN;
                    end
                    else
                    begin
                        cmd.repeat_inc = 1'b1;
                        if (st.keep_going)
                        begin
                            cmd.stage_zero = 1'b1;
                            fa_next        = 1'b1;
                            state_next     = S_BEGIN;
                        end
                        else
                        begin
                            // pattern over: drop its own mode
                            cmd.en_clr_cur = 1'b1;
                            state_next     = S_PICK_CHK;
                        end
                    end
                end
                else
                begin
                    state_next = st.fade_active ? S_FADE_STEP : S_DONE;
                end
            end
            S_PICK_CHK:
            begin
                if (force_reg || st.pick_change)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_BEGIN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BEGIN:
            begin
                if (st.stage_in)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DUR;
                    state_next    = S_WAIT_DUR;
                end
                else
                begin
                    cmd.blank  = 1'b1;
                    state_next = S_POST;
                end
            end
            S_WAIT_DUR:
            begin
                if (st.div_done)
                begin
                    cmd.set_deadline = 1'b1;
                    cmd.div_start    = 1'b1;
                    cmd.div_sel      = DIV_FADE;
                    state_next       = S_WAIT_FADE;
                end
            end
            S_WAIT_FADE:
            begin
                if (st.div_done)
                begin
                    cmd.latch_ft = 1'b1;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                ch_next = 2'd0;
                if (st.ft_zero)
                begin
                    cmd.jump   = 1'b1;
                    state_next = S_POST;
                end
                else
                begin
                    cmd.fade_setup = 1'b1;
                    state_next     = S_CH;
                end
            end
            S_CH:
            begin
                cmd.div_sel = DIV_MAG;
                if (st.mag_zero)
                begin
                    cmd.step_zero = 1'b1;
                    if (ch_reg == 2'd2)
                    begin
                        cmd.fade_on = 1'b1;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAIT_CH;
                end
            end
            S_WAIT_CH:
            begin
                cmd.div_sel = DIV_MAG;
                if (st.div_done)
                begin
                    cmd.step_latch = 1'b1;
                    if (ch_reg == 2'd2)
                    begin
                        cmd.fade_on = 1'b1;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_CH;
                    end
                end
            end
            S_POST:
            begin
                state_next = (fa_reg && st.fade_active) ? S_FADE_STEP : S_DONE;
            end
            S_FADE_STEP:
            begin
                cmd.fade_step = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!(ov_reg && out_stall))
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
endmodule

// ===== rtl/core/lpfs_datapath.sv =====
// Sequencer state, pattern lookup, fade arithmetic and result registers.
// Depends on lpfs_pkg and lpfs_div.
module lpfs_datapath
    import lpfs_pkg::*;
#(
    parameter int MODE_COUNT = 5,
    parameter int MAX_STAGES = 8,
    parameter int STEP_LIMIT = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    st,
    input  logic [2:0] mode,
    input  logic       enable,
    input  logic [9:0] period,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       fading,
    output logic [2:0] shown_mode,
    output logic [3:0] stage_index
);
    localparam int PICK_TOP = ((MODE_COUNT < ROM_MODES) ? MODE_COUNT : ROM_MODES) - 1;

    logic [TICK_W-1:0]    tick_reg, dl_reg;
    logic [CNT_W-1:0]     stage_reg, rep_reg;
    logic                 run_reg, fa_reg;
    logic [2:0]           cur_mode_reg, mode_in_reg;
    logic                 en_in_reg;
    logic [ROM_MODES-1:0] ena_reg;
    logic [7:0]           cur_reg [CH_N];
    logic [7:0]           tgt_reg [CH_N];
    logic [7:0]           smag_reg [CH_N];
    logic                 sneg_reg [CH_N];
    logic [MS_W-1:0]      ft_reg;
    logic [7:0]           o_r_reg, o_g_reg, o_b_reg;
    logic                 o_f_reg;
    logic [2:0]           o_m_reg;
    logic [3:0]           o_s_reg;

    stage_t          srom;
    logic [3:0]      total;
    logic [2:0]      best;
    logic [9:0]      p_eff;
    logic [MS_W-1:0] dnum, dden, quo;
    logic            ddone;
    logic [7:0]      mag;
    logic            neg;
    logic [7:0]      cnew [CH_N];
    logic            same;
    logic [8:0]      qp1;
    logic [7:0]      stepv;
    logic [7:0]      lvl [CH_N];

    assign srom  = stage_rom(cur_mode_reg, stage_reg[2:0]);
    assign total = (int'(rom_count(cur_mode_reg)) < MAX_STAGES) ? rom_count(cur_mode_reg)
                                                                : 4'(MAX_STAGES);
    assign p_eff = (period == 10'd0) ? 10'd1 : period;
    assign lvl[0] = srom.r;
    assign lvl[1] = srom.g;
    assign lvl[2] = srom.b;

    always_comb
    begin
        best = 3'd0;
        for (int i = 0; i <= PICK_TOP; i++)
        begin
            if (ena_reg[i])
            begin
                best = 3'(i);
            end
        end
    end

    // magnitude of the channel under fade setup
    always_comb
    begin
        neg = tgt_reg[cmd.ch] < cur_reg[cmd.ch];
        mag = neg ? (cur_reg[cmd.ch] - tgt_reg[cmd.ch]) : (tgt_reg[cmd.ch] - cur_reg[cmd.ch]);
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DUR:  dnum = srom.dur;
            DIV_FADE: dnum = srom.fade;
            default:  dnum = MS_W'(mag - 8'd1);
        endcase
        dden = (cmd.div_sel == DIV_MAG) ? ft_reg : MS_W'(p_eff);
    end

    lpfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .done  (ddone),
        .quo   (quo)
    );

    assign qp1   = {1'b0, quo[7:0]} + 9'd1;
    assign stepv = (qp1 > 9'(STEP_LIMIT)) ? 8'(STEP_LIMIT) : qp1[7:0];

    always_comb
    begin
        logic [8:0] s9;
        s9   = '0;
        same = 1'b1;
        for (int i = 0; i < CH_N; i++)
        begin
            if (cur_reg[i] != tgt_reg[i])
            begin
                same = 1'b0;
            end
            cnew[i] = cur_reg[i];
            if (smag_reg[i] != 8'd0)
            begin
                if (!sneg_reg[i])
                begin
                    s9 = {1'b0, cur_reg[i]} + {1'b0, smag_reg[i]};
                    cnew[i] = (s9 > {1'b0, tgt_reg[i]}) ? tgt_reg[i] : s9[7:0];
                end
                else
                begin
                    s9 = {1'b0, cur_reg[i]} - {1'b0, smag_reg[i]};
                    cnew[i] = (s9[8] || (s9[7:0] < tgt_reg[i])) ? tgt_reg[i] : s9[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            dl_reg       <= '0;
            stage_reg    <= '0;
            rep_reg      <= '0;
            run_reg      <= 1'b0;
            fa_reg       <= 1'b0;
            cur_mode_reg <= 3'd0;
            ena_reg      <= '0;
            ft_reg       <= '0;
            for (int i = 0; i < CH_N; i++)
            begin
                cur_reg[i]  <= 8'd0;
                tgt_reg[i]  <= 8'd0;
                smag_reg[i] <= 8'd0;
                sneg_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.pause)
            begin
                run_reg <= 1'b0;
            end
            if (cmd.en_write_item)
            begin
                ena_reg[mode_in_reg] <= en_in_reg;
            end
            if (cmd.en_clr_cur)
            begin
                ena_reg[cur_mode_reg] <= 1'b0;
            end
            if (cmd.stage_zero)
            begin
                stage_reg <= '0;
            end
            else if (cmd.stage_inc)
            begin
                stage_reg <= stage_reg + 1'b1;
            end
            if (cmd.repeat_inc)
            begin
                rep_reg <= rep_reg + 1'b1;
            end
            if (cmd.pick)
            begin
                if (!rom_forever(cur_mode_reg))
                begin
                    ena_reg[cur_mode_reg] <= 1'b0;
                end
                cur_mode_reg <= best;
                run_reg      <= 1'b1;
                stage_reg    <= '0;
                rep_reg      <= '0;
            end
            if (cmd.blank)
            begin
                fa_reg <= 1'b0;
                dl_reg <= '0;
                for (int i = 0; i < CH_N; i++)
                begin
                    cur_reg[i] <= 8'd0;
                end
            end
            if (cmd.set_deadline)
            begin
                dl_reg <= tick_reg + TICK_W'(quo);
            end
            if (cmd.latch_ft)
            begin
                ft_reg <= quo;
            end
            if (cmd.jump)
            begin
                fa_reg <= 1'b0;
                for (int i = 0; i < CH_N; i++)
                begin
                    cur_reg[i] <= lvl[i];
                end
            end
            if (cmd.fade_setup)
            begin
                for (int i = 0; i < CH_N; i++)
                begin
                    if (fa_reg)
                    begin
                        cur_reg[i] <= tgt_reg[i];
                    end
                    tgt_reg[i] <= lvl[i];
                end
            end
            if (cmd.step_zero)
            begin
                smag_reg[cmd.ch] <= 8'd0;
                sneg_reg[cmd.ch] <= 1'b0;
            end
            if (cmd.step_latch)
            begin
                smag_reg[cmd.ch] <= stepv;
                sneg_reg[cmd.ch] <= neg;
            end
            if (cmd.fade_on)
            begin
                fa_reg <= 1'b1;
            end
            if (cmd.fade_step)
            begin
                if (same)
                begin
                    fa_reg <= 1'b0;
                end
                else
                begin
                    for (int i = 0; i < CH_N; i++)
                    begin
                        cur_reg[i] <= cnew[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            mode_in_reg <= mode;
            en_in_reg   <= enable;
        end
        if (cmd.out_load)
        begin
            o_r_reg <= cur_reg[0];
            o_g_reg <= cur_reg[1];
            o_b_reg <= cur_reg[2];
            o_f_reg <= fa_reg;
            o_m_reg <= cur_mode_reg;
            o_s_reg <= stage_reg[3:0];
        end
    end

    always_comb
    begin
        st              = '0;
        st.running      = run_reg;
        st.mode_ok      = (int'(mode_in_reg) < MODE_COUNT) && (int'(mode_in_reg) < ROM_MODES);
        st.deadline_hit = (dl_reg != '0) && (tick_reg > dl_reg);
        st.last_stage   = ((stage_reg + 8'd1) >= {4'd0, total});
        st.keep_going   = rom_forever(cur_mode_reg) ||
                          ((rep_reg + 1'b1) < rom_passes(cur_mode_reg));
        st.pick_change  = (best != cur_mode_reg);
        st.stage_in     = (stage_reg < {4'd0, total});
        st.div_done     = ddone;
        st.ft_zero      = (ft_reg == '0);
        st.mag_zero     = (mag == 8'd0);
        st.fade_active  = fa_reg;
    end

    assign red         = o_r_reg;
    assign green       = o_g_reg;
    assign blue        = o_b_reg;
    assign fading      = o_f_reg;
    assign shown_mode  = o_m_reg;
    assign stage_index = o_s_reg;
endmodule

// ===== rtl/core/lpfs_checker.sv =====
// Port-level checks for the LED pattern fade sequencer, bound to the top.
// Depends only on the top level's ports.
module lpfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] shown_mode
);
    // one word in flight: block stalls right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shown_mode <= 3'd4))
        else $error("shown mode out of range");
endmodule

bind led_pattern_fade_sequencer lpfs_checker u_lpfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .shown_mode (shown_mode)
);
